// ===== rtl/mtst_pkg.sv =====
// mtst_pkg: shared constants, tag table, state and batch types of the
// markup tag style tracker. No dependencies; the modules use it.
`default_nettype none

package mtst_pkg;

    // fixed sizes
    localparam int NUM_TAGS    = 12;
    localparam int MAX_TAG_LEN = 8;
    localparam int MAX_RES     = 8;
    localparam int POS_BITS    = 3;
    localparam int CNT_BITS    = 4;
    localparam int COLOR_BITS  = 24;
    localparam int SIZE_BITS   = 16;
    localparam int CHAR_W      = 16;

    // parser phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_MATCH = 3'd1;
    localparam logic [2:0] PH_COLOR = 3'd2;
    localparam logic [2:0] PH_SIZE  = 3'd3;
    localparam logic [2:0] PH_URL   = 3'd4;

    // tag indexes
    localparam logic [3:0] TAG_B_ON      = 4'd0;
    localparam logic [3:0] TAG_B_OFF     = 4'd1;
    localparam logic [3:0] TAG_I_ON      = 4'd2;
    localparam logic [3:0] TAG_I_OFF     = 4'd3;
    localparam logic [3:0] TAG_U_ON      = 4'd4;
    localparam logic [3:0] TAG_U_OFF     = 4'd5;
    localparam logic [3:0] TAG_COLOR_ON  = 4'd6;
    localparam logic [3:0] TAG_COLOR_OFF = 4'd7;
    localparam logic [3:0] TAG_SIZE_ON   = 4'd8;
    localparam logic [3:0] TAG_SIZE_OFF  = 4'd9;
    localparam logic [3:0] TAG_LINK_ON   = 4'd10;
    localparam logic [3:0] TAG_LINK_OFF  = 4'd11;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_GT    = 16'h003e;
    localparam logic [CHAR_W-1:0] CH_0     = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_9     = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 16'h005a;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LC_F  = 16'h0066;
    localparam logic [CHAR_W-1:0] CASE_BIT = 16'h0020;

    // style constants
    localparam logic [COLOR_BITS-1:0] LINK_COLOR     = 24'hff0000;
    localparam logic [SIZE_BITS-1:0]  SIZE_RESET     = 16'd8;
    localparam logic [SIZE_BITS-1:0]  SIZE_MAX       = 16'hffff;

    // configuration register map (word index taken from paddr[2])
    localparam int          CFG_ADDR_BITS  = 3;
    localparam logic        REG_DFLT_SIZE  = 1'b0;

    typedef struct packed {
        logic [2:0]            phase;
        logic [NUM_TAGS-1:0]   cand;
        logic [POS_BITS-1:0]   mp;
        logic [COLOR_BITS-1:0] acc;
        logic                  bold;
        logic                  italic;
        logic                  underline;
        logic [COLOR_BITS-1:0] color;
        logic [SIZE_BITS-1:0]  size;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase: PH_IDLE, cand: '0, mp: '0, acc: '0,
        bold: 1'b0, italic: 1'b0, underline: 1'b0,
        color: '0, size: SIZE_RESET
    };

    // result batch of one input item, with the style after the step
    typedef struct packed {
        logic [CNT_BITS-1:0]            count;
        logic [MAX_RES-1:0][CHAR_W-1:0] chars;
        logic                           url;
        logic                           bold;
        logic                           italic;
        logic                           underline;
        logic [COLOR_BITS-1:0]          color;
        logic [SIZE_BITS-1:0]           size;
        logic                           dflt;
    } batch_t;

    // ascii upper case to lower case
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        if (c >= CH_UC_A && c <= CH_UC_Z)
            return c | CASE_BIT;
        return c;
    endfunction

    // tag text, first character in the top byte, padded with spaces
    function automatic logic [63:0] tag_str(input logic [3:0] t);
        logic [63:0] s;
        unique case (t)
            TAG_B_ON:      s = "<b>     ";
            TAG_B_OFF:     s = "</b>    ";
            TAG_I_ON:      s = "<i>     ";
            TAG_I_OFF:     s = "</i>    ";
            TAG_U_ON:      s = "<u>     ";
            TAG_U_OFF:     s = "</u>    ";
            TAG_COLOR_ON:  s = "<color= ";
            TAG_COLOR_OFF: s = "</color>";
            TAG_SIZE_ON:   s = "<size=  ";
            TAG_SIZE_OFF:  s = "</size> ";
            TAG_LINK_ON:   s = "<a=     ";
            TAG_LINK_OFF:  s = "</a>    ";
            default:       s = 64'h0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] tag_len(input logic [3:0] t);
        logic [3:0] n;
        unique case (t)
            TAG_B_ON:      n = 4'd3;
            TAG_B_OFF:     n = 4'd4;
            TAG_I_ON:      n = 4'd3;
            TAG_I_OFF:     n = 4'd4;
            TAG_U_ON:      n = 4'd3;
            TAG_U_OFF:     n = 4'd4;
            TAG_COLOR_ON:  n = 4'd7;
            TAG_COLOR_OFF: n = 4'd8;
            TAG_SIZE_ON:   n = 4'd6;
            TAG_SIZE_OFF:  n = 4'd7;
            TAG_LINK_ON:   n = 4'd3;
            TAG_LINK_OFF:  n = 4'd4;
            default:       n = 4'd0;
        endcase
        return n;
    endfunction

    // folded character matches tag t at position pos
    function automatic logic tag_hit(input logic [3:0] t,
                                     input logic [POS_BITS-1:0] pos,
                                     input logic [CHAR_W-1:0] fc);
        logic [63:0] s;
        logic [7:0]  b;
        s = tag_str(t);
        b = s[63 - 8*pos -: 8];
        return ({1'b0, pos} < tag_len(t)) && (fc == {8'h00, b});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mtst_in_if.sv =====
// mtst_in_if: input character channel, one character per beat.
// Depends on no other file.
`default_nettype none

interface mtst_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] ch;
    logic        end_of_text;

    modport source (output valid, ch, end_of_text, input ready);
    modport sink   (input valid, ch, end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/mtst_out_if.sv =====
// mtst_out_if: result channel, one emitted character with its style per beat.
// Depends on no other file.
`default_nettype none

interface mtst_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] text_char;
    logic        is_text;
    logic        is_url_char;
    logic        bold_on;
    logic        italic_active;
    logic        underline_active;
    logic [23:0] text_color;
    logic [15:0] text_size;
    logic        default_style;
    logic        last;

    modport source (output valid, text_char, is_text, is_url_char, bold_on,
                    italic_active, underline_active, text_color, text_size,
                    default_style, last, input ready);
    modport sink   (input valid, text_char, is_text, is_url_char, bold_on,
                    italic_active, underline_active, text_color, text_size,
                    default_style, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/mtst_cfg.sv =====
// mtst_cfg: APB-style configuration port holding default_text_size.
// Depends on mtst_pkg.
`default_nettype none

module mtst_cfg (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mtst_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  wire logic [31:0]                          pwdata,
    output logic      [31:0]                          prdata,
    output logic                                      pready,
    output logic      [mtst_pkg::SIZE_BITS-1:0]       default_text_size
);

    logic                               wr_en;
    logic                               sel_dflt;
    logic [mtst_pkg::SIZE_BITS-1:0]     dflt_size_reg;
    logic [mtst_pkg::SIZE_BITS-1:0]     dflt_size_next;

    // word decode; byte lanes inside the word are ignored
    assign sel_dflt = (paddr[2] == mtst_pkg::REG_DFLT_SIZE);
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;

    // register write
    always_comb
    begin
        dflt_size_next = dflt_size_reg;
        if (wr_en && sel_dflt)
            dflt_size_next = pwdata[mtst_pkg::SIZE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dflt_size_reg <= mtst_pkg::SIZE_RESET;
        else
            dflt_size_reg <= dflt_size_next;
    end

    // read back
    always_comb
    begin
        prdata = 32'h0;
        if (sel_dflt)
            prdata = {{(32 - mtst_pkg::SIZE_BITS){1'b0}}, dflt_size_reg};
    end

    assign default_text_size = dflt_size_reg;

endmodule

`default_nettype wire

// ===== rtl/mtst_core.sv =====
// mtst_core: input register, parser state and held tag characters, and the
// single-pass step logic that builds one result batch per character.
// Depends on mtst_pkg and mtst_in_if.
`default_nettype none

module mtst_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    mtst_in_if.sink                                 din,
    input  wire logic [mtst_pkg::SIZE_BITS-1:0]     default_text_size,
    input  wire logic                               batch_free,
    output mtst_pkg::batch_t                        batch,
    output logic                                    batch_load
);

    localparam int NT = mtst_pkg::NUM_TAGS;
    localparam int PB = mtst_pkg::POS_BITS;
    localparam int CW = mtst_pkg::CHAR_W;

    logic                   in_valid_reg;
    logic [CW-1:0]          ch_reg;
    logic                   eot_reg;
    logic                   adv;

    mtst_pkg::state_t       state_reg;
    mtst_pkg::state_t       state_next;
    logic [CW-1:0]          pend_reg [mtst_pkg::MAX_TAG_LEN];

    logic [CW-1:0]          fc;
    logic [NT-1:0]          start_mask;
    logic [NT-1:0]          match_mask;
    logic [PB:0]            mp1;
    logic                   done_hit;
    logic [3:0]             done_idx;
    logic                   is_dig;
    logic                   is_hex_lc;
    logic [3:0]             nib;
    logic [19:0]            size_prod;

    logic [mtst_pkg::CNT_BITS-1:0]                     cnt;
    logic [mtst_pkg::MAX_RES-1:0][CW-1:0]              chars;
    logic                   url;
    logic                   pend_we;
    logic [PB-1:0]          pend_idx;

    // outer bytes swapped into blue-green-red order
    function automatic logic [23:0] swap_rgb(input logic [23:0] p);
        return {p[7:0], p[15:8], p[23:16]};
    endfunction

    assign adv       = in_valid_reg && batch_free;
    assign din.ready = !in_valid_reg || batch_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (din.valid && din.ready)
            in_valid_reg <= 1'b1;
        else if (adv)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            ch_reg  <= din.ch;
            eot_reg <= din.end_of_text;
        end
    end

    // tag compares against the whole table
    always_comb
    begin
        fc         = mtst_pkg::fold(ch_reg);
        start_mask = '0;
        match_mask = '0;
        for (int t = 0; t < NT; t++)
        begin
            start_mask[t] = mtst_pkg::tag_hit(4'(t), '0, fc);
            match_mask[t] = state_reg.cand[t] &&
                            mtst_pkg::tag_hit(4'(t), state_reg.mp, fc);
        end
        mp1      = {1'b0, state_reg.mp} + 1'b1;
        done_hit = 1'b0;
        done_idx = '0;
        for (int t = 0; t < NT; t++)
        begin
            if (match_mask[t] && (mtst_pkg::tag_len(4'(t)) == mp1))
            begin
                done_hit = 1'b1;
                done_idx = 4'(t);
            end
        end
    end

    // parameter digits
    always_comb
    begin
        is_dig    = (ch_reg >= mtst_pkg::CH_0) && (ch_reg <= mtst_pkg::CH_9);
        is_hex_lc = (fc >= mtst_pkg::CH_LC_A) && (fc <= mtst_pkg::CH_LC_F);
        nib       = is_dig ? ch_reg[3:0] : (fc[3:0] + 4'd9);
        size_prod = {1'b0, state_reg.acc[15:0], 3'b000}
                  + {3'b000, state_reg.acc[15:0], 1'b0}
                  + {16'h0, ch_reg[3:0]};
    end

    // one step of the parser
    always_comb
    begin
        state_next = state_reg;
        cnt        = '0;
        url        = 1'b0;
        pend_we    = 1'b0;
        pend_idx   = state_reg.mp;

        // held characters first, then the current one
        for (int k = 0; k < mtst_pkg::MAX_RES; k++)
            chars[k] = (PB'(k) < state_reg.mp) ? pend_reg[k] : ch_reg;

        unique case (state_reg.phase)
            mtst_pkg::PH_MATCH:
            begin
                if (match_mask == '0)
                begin
                    // failed partial tag: replay, then treat as idle
                    if (start_mask != '0)
                    begin
                        state_next.phase = mtst_pkg::PH_MATCH;
                        state_next.cand  = start_mask;
                        state_next.mp    = PB'(1);
                        pend_we          = 1'b1;
                        pend_idx         = '0;
                        cnt              = {1'b0, state_reg.mp};
                    end
                    else
                    begin
                        state_next.phase = mtst_pkg::PH_IDLE;
                        state_next.cand  = '0;
                        state_next.mp    = '0;
                        cnt              = mp1;
                    end
                end
                else
                begin
                    pend_we         = 1'b1;
                    state_next.cand = match_mask;
                    if (done_hit)
                    begin
                        state_next.phase = mtst_pkg::PH_IDLE;
                        state_next.cand  = '0;
                        state_next.mp    = '0;
                        state_next.acc   = '0;
                        unique case (done_idx)
                            mtst_pkg::TAG_B_ON:      state_next.bold = 1'b1;
                            mtst_pkg::TAG_B_OFF:     state_next.bold = 1'b0;
                            mtst_pkg::TAG_I_ON:      state_next.italic = 1'b1;
                            mtst_pkg::TAG_I_OFF:     state_next.italic = 1'b0;
                            mtst_pkg::TAG_U_ON:      state_next.underline = 1'b1;
                            mtst_pkg::TAG_U_OFF:     state_next.underline = 1'b0;
                            mtst_pkg::TAG_COLOR_ON:  state_next.phase = mtst_pkg::PH_COLOR;
                            mtst_pkg::TAG_COLOR_OFF: state_next.color = '0;
                            mtst_pkg::TAG_SIZE_ON:   state_next.phase = mtst_pkg::PH_SIZE;
                            mtst_pkg::TAG_SIZE_OFF:  state_next.size = default_text_size;
                            mtst_pkg::TAG_LINK_ON:
                            begin
                                state_next.underline = 1'b1;
                                state_next.color     = mtst_pkg::LINK_COLOR;
                                state_next.phase     = mtst_pkg::PH_URL;
                            end
                            mtst_pkg::TAG_LINK_OFF:
                            begin
                                state_next.underline = 1'b0;
                                state_next.color     = '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else if (mp1 == (PB+1)'(mtst_pkg::MAX_TAG_LEN))
                    begin
                        // buffer full with no tag: replay all
                        state_next.phase = mtst_pkg::PH_IDLE;
                        state_next.cand  = '0;
                        state_next.mp    = '0;
                        cnt              = mtst_pkg::CNT_BITS'(mtst_pkg::MAX_TAG_LEN);
                    end
                    else
                    begin
                        state_next.mp = mp1[PB-1:0];
                    end
                end
            end

            mtst_pkg::PH_COLOR:
            begin
                if (is_dig || is_hex_lc)
                    state_next.acc = {state_reg.acc[19:0], nib};
                else
                begin
                    state_next.color = swap_rgb(state_reg.acc);
                    state_next.acc   = '0;
                    state_next.phase = mtst_pkg::PH_IDLE;
                end
            end

            mtst_pkg::PH_SIZE:
            begin
                if (is_dig)
                begin
                    if (size_prod > {4'h0, mtst_pkg::SIZE_MAX})
                        state_next.acc = {8'h00, mtst_pkg::SIZE_MAX};
                    else
                        state_next.acc = {4'h0, size_prod};
                end
                else
                begin
                    state_next.size  = state_reg.acc[15:0];
                    state_next.acc   = '0;
                    state_next.phase = mtst_pkg::PH_IDLE;
                end
            end

            mtst_pkg::PH_URL:
            begin
                if (ch_reg == mtst_pkg::CH_SPACE || ch_reg == mtst_pkg::CH_GT)
                    state_next.phase = mtst_pkg::PH_IDLE;
                else
                begin
                    cnt = mtst_pkg::CNT_BITS'(1);
                    url = 1'b1;
                end
            end

            default:
            begin
                state_next.phase = mtst_pkg::PH_IDLE;
                if (start_mask != '0)
                begin
                    state_next.phase = mtst_pkg::PH_MATCH;
                    state_next.cand  = start_mask;
                    state_next.mp    = PB'(1);
                    pend_we          = 1'b1;
                    pend_idx         = '0;
                end
                else
                    cnt = mtst_pkg::CNT_BITS'(1);
            end
        endcase

        // end of text: flush held tag, close parameter, leave link
        if (eot_reg)
        begin
            if (state_next.phase == mtst_pkg::PH_MATCH)
            begin
                cnt             = cnt + {1'b0, state_next.mp};
                state_next.cand = '0;
                state_next.mp   = '0;
            end
            else if (state_next.phase == mtst_pkg::PH_COLOR)
            begin
                state_next.color = swap_rgb(state_next.acc);
                state_next.acc   = '0;
            end
            else if (state_next.phase == mtst_pkg::PH_SIZE)
            begin
                state_next.size = state_next.acc[15:0];
                state_next.acc  = '0;
            end
            state_next.phase = mtst_pkg::PH_IDLE;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mtst_pkg::STATE_RESET;
        else if (adv)
            state_reg <= state_next;
    end

    // held tag characters
    always_ff @(posedge clk)
    begin
        if (adv && pend_we)
            pend_reg[pend_idx] <= ch_reg;
    end

    // batch toward the output stage
    always_comb
    begin
        batch.count     = cnt;
        batch.chars     = chars;
        batch.url       = url;
        batch.bold      = state_next.bold;
        batch.italic    = state_next.italic;
        batch.underline = state_next.underline;
        batch.color     = state_next.color;
        batch.size      = state_next.size;
        batch.dflt      = !state_next.bold && !state_next.italic &&
                          !state_next.underline &&
                          (state_next.size == default_text_size);
    end

    assign batch_load = adv;

endmodule

`default_nettype wire

// ===== rtl/mtst_emit.sv =====
// mtst_emit: result register that holds one batch and sends its characters
// one beat per cycle unless stalled. Depends on mtst_pkg and mtst_out_if.
`default_nettype none

module mtst_emit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mtst_pkg::batch_t batch,
    input  wire logic           batch_load,
    output logic                batch_free,
    mtst_out_if.source          dout
);

    localparam int RB = $clog2(mtst_pkg::MAX_RES);

    mtst_pkg::batch_t               batch_reg;
    logic                           valid_reg;
    logic [RB-1:0]                  idx_reg;
    logic [mtst_pkg::CNT_BITS-1:0]  cnt_m1;
    logic                           last_beat;
    logic                           fire;

    assign cnt_m1     = batch_reg.count - 1'b1;
    assign last_beat  = ({1'b0, idx_reg} == cnt_m1);
    assign fire       = valid_reg && dout.ready;
    assign batch_free = !valid_reg || (dout.ready && last_beat);

    // beat sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (batch_load)
        begin
            valid_reg <= (batch.count != '0);
            idx_reg   <= '0;
        end
        else if (fire)
        begin
            if (last_beat)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    // batch payload
    always_ff @(posedge clk)
    begin
        if (batch_load)
            batch_reg <= batch;
    end

    // output beat
    assign dout.valid            = valid_reg;
    assign dout.text_char        = batch_reg.chars[idx_reg];
    assign dout.is_text          = !batch_reg.url;
    assign dout.is_url_char      = batch_reg.url;
    assign dout.bold_on          = batch_reg.bold;
    assign dout.italic_active    = batch_reg.italic;
    assign dout.underline_active = batch_reg.underline;
    assign dout.text_color       = batch_reg.color;
    assign dout.text_size        = batch_reg.size;
    assign dout.default_style    = batch_reg.dflt;
    assign dout.last             = last_beat;

endmodule

`default_nettype wire

// ===== rtl/markup_tag_style_tracker_top.sv =====
// markup_tag_style_tracker_top: top level of the markup tag style tracker.
// Depends on mtst_pkg, mtst_in_if, mtst_out_if, mtst_cfg, mtst_core, mtst_emit.
//
// The block takes one character per input beat and tracks the style tags
// <b> <i> <u> <color= <size= <a= and their closing forms, matched without
// regard to letter case. Each input character is registered, run through the
// tag compare and state update, and its results (zero to eight characters,
// all carrying the style after that character) land in a result register,
// from which its first beat is offered. The result register sends one beat
// per cycle while dout.ready is high, so an input character is taken every
// cycle while each one gives at most one result; a character whose batch
// has more than one beat (a failed partial tag replays its held characters,
// up to eight beats in all) holds the input side while its beats drain. Tag
// completions and parameter characters give no beats. The user must write
// default_text_size through the APB-style port at byte address 0 while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module markup_tag_style_tracker_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    mtst_in_if.sink                                   din,
    mtst_out_if.source                                dout,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mtst_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  wire logic [31:0]                          pwdata,
    output logic      [31:0]                          prdata,
    output logic                                      pready
);

    logic [mtst_pkg::SIZE_BITS-1:0] default_text_size;
    mtst_pkg::batch_t               batch;
    logic                           batch_load;
    logic                           batch_free;

    // configuration register
    mtst_cfg u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .default_text_size (default_text_size)
    );

    // parser
    mtst_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .din               (din),
        .default_text_size (default_text_size),
        .batch_free        (batch_free),
        .batch             (batch),
        .batch_load        (batch_load)
    );

    // result beats
    mtst_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .batch      (batch),
        .batch_load (batch_load),
        .batch_free (batch_free),
        .dout       (dout)
    );

    // no batch larger than the result register
    a_batch_count: assert property (@(posedge clk) disable iff (!rst_n)
        batch_load |-> (batch.count <= mtst_pkg::CNT_BITS'(mtst_pkg::MAX_RES)))
        else $error("batch count exceeds result slots");

    // a link character is always the only result of its step
    a_url_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.is_url_char) |-> dout.last)
        else $error("link character not last of its step");

    // more beats of the same batch follow a non-last beat
    a_batch_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.ready && !dout.last) |=> dout.valid)
        else $error("batch dropped before its last beat");

    // a stalled result register never takes a new batch
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.ready) |-> !batch_load)
        else $error("batch loaded over a pending beat");

endmodule

`default_nettype wire

// ===== tb/tb_markup_tag_style_tracker_top.sv =====
// tb_markup_tag_style_tracker_top: self-checking testbench of the markup tag style tracker.
// Depends on mtst_pkg, mtst_in_if, mtst_out_if and markup_tag_style_tracker_top.
// Characters go in with random gaps, result beats are checked against a built-in style predictor.
`default_nettype none

module tb_markup_tag_style_tracker_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS = 10;
    localparam logic [mtst_pkg::CFG_ADDR_BITS-1:0] DFLT_SIZE_ADDR =
        {mtst_pkg::REG_DFLT_SIZE, 2'b00};

    // one result beat as seen on the output channel
    typedef struct packed {
        logic [15:0] text_char;
        logic        is_text;
        logic        is_url_char;
        logic        bold_on;
        logic        italic_active;
        logic        underline_active;
        logic [23:0] text_color;
        logic [15:0] text_size;
        logic        default_style;
        logic        last;
    } style_beat_t;

    // one character to send
    typedef struct packed {
        logic [15:0] ch;
        logic        eot;
    } char_item_t;

    // predicts the styled characters of each input character and holds them until seen
    class markup_style_predictor;
        logic [15:0] dflt_size;
        logic [2:0]  phase;
        logic [11:0] cand;
        int          mp;
        logic [15:0] held[mtst_pkg::MAX_TAG_LEN];
        logic [23:0] acc;
        logic        bold;
        logic        italic;
        logic        uline;
        logic [23:0] color;
        logic [15:0] style_size;
        logic [15:0] em_ch[mtst_pkg::MAX_RES];
        logic        em_url[mtst_pkg::MAX_RES];
        int          em_n;
        style_beat_t expected_beats[$];
        int          errors;

        function new();
            dflt_size = mtst_pkg::SIZE_RESET;
            phase = mtst_pkg::PH_IDLE;
            cand = '0;
            mp = 0;
            acc = '0;
            bold = 1'b0;
            italic = 1'b0;
            uline = 1'b0;
            color = '0;
            style_size = mtst_pkg::SIZE_RESET;
            em_n = 0;
            errors = 0;
        endfunction

        function string tag_spelling(int t);
            case (t)
                mtst_pkg::TAG_B_ON:      return "<b>";
                mtst_pkg::TAG_B_OFF:     return "</b>";
                mtst_pkg::TAG_I_ON:      return "<i>";
                mtst_pkg::TAG_I_OFF:     return "</i>";
                mtst_pkg::TAG_U_ON:      return "<u>";
                mtst_pkg::TAG_U_OFF:     return "</u>";
                mtst_pkg::TAG_COLOR_ON:  return "<color=";
                mtst_pkg::TAG_COLOR_OFF: return "</color>";
                mtst_pkg::TAG_SIZE_ON:   return "<size=";
                mtst_pkg::TAG_SIZE_OFF:  return "</size>";
                mtst_pkg::TAG_LINK_ON:   return "<a=";
                default:                 return "</a>";
            endcase
        endfunction

        function logic [15:0] lower(logic [15:0] c);
            if (c >= mtst_pkg::CH_UC_A && c <= mtst_pkg::CH_UC_Z)
                return c | mtst_pkg::CASE_BIT;
            return c;
        endfunction

        function bit tag_has(int t, int pos, logic [15:0] c);
            string s;
            s = tag_spelling(t);
            if (pos >= s.len())
                return 1'b0;
            return lower(c) == {8'h00, s[pos]};
        endfunction

        function void emit(logic [15:0] c, logic url);
            if (em_n < mtst_pkg::MAX_RES)
            begin
                em_ch[em_n] = c;
                em_url[em_n] = url;
                em_n++;
            end
        endfunction

        // a character seen outside a tag either opens a match or is plain text
        function void open_or_text(logic [15:0] c);
            logic [11:0] m;
            m = '0;
            for (int t = 0; t < mtst_pkg::NUM_TAGS; t++)
                if (tag_has(t, 0, c))
                    m[t] = 1'b1;
            if (m != '0)
            begin
                phase = mtst_pkg::PH_MATCH;
                cand = m;
                held[0] = c;
                mp = 1;
            end
            else
                emit(c, 1'b0);
        endfunction

        // held characters of a failed tag come out as text
        function void flush_held();
            for (int k = 0; k < mp && k < mtst_pkg::MAX_TAG_LEN; k++)
                emit(held[k], 1'b0);
            phase = mtst_pkg::PH_IDLE;
            cand = '0;
            mp = 0;
        endfunction

        function void take_tag(int t);
            phase = mtst_pkg::PH_IDLE;
            cand = '0;
            mp = 0;
            acc = '0;
            case (t)
                mtst_pkg::TAG_B_ON:      bold = 1'b1;
                mtst_pkg::TAG_B_OFF:     bold = 1'b0;
                mtst_pkg::TAG_I_ON:      italic = 1'b1;
                mtst_pkg::TAG_I_OFF:     italic = 1'b0;
                mtst_pkg::TAG_U_ON:      uline = 1'b1;
                mtst_pkg::TAG_U_OFF:     uline = 1'b0;
                mtst_pkg::TAG_COLOR_ON:  phase = mtst_pkg::PH_COLOR;
                mtst_pkg::TAG_COLOR_OFF: color = '0;
                mtst_pkg::TAG_SIZE_ON:   phase = mtst_pkg::PH_SIZE;
                mtst_pkg::TAG_SIZE_OFF:  style_size = dflt_size;
                mtst_pkg::TAG_LINK_ON:
                begin
                    uline = 1'b1;
                    color = mtst_pkg::LINK_COLOR;
                    phase = mtst_pkg::PH_URL;
                end
                default:
                begin
                    uline = 1'b0;
                    color = '0;
                end
            endcase
        endfunction

        // colour is stored with outer bytes swapped
        function void close_param();
            if (phase == mtst_pkg::PH_COLOR)
                color = {acc[7:0], acc[15:8], acc[23:16]};
            else if (phase == mtst_pkg::PH_SIZE)
                style_size = acc[15:0];
            phase = mtst_pkg::PH_IDLE;
            acc = '0;
        endfunction

        function void match_step(logic [15:0] c);
            logic [11:0] m;
            int done;
            string s;
            m = '0;
            done = -1;
            for (int t = 0; t < mtst_pkg::NUM_TAGS; t++)
                if (cand[t] && tag_has(t, mp, c))
                    m[t] = 1'b1;
            if (m == '0)
            begin
                flush_held();
                open_or_text(c);
                return;
            end
            if (mp < mtst_pkg::MAX_TAG_LEN)
                held[mp] = c;
            mp++;
            cand = m;
            for (int t = 0; t < mtst_pkg::NUM_TAGS; t++)
            begin
                s = tag_spelling(t);
                if (m[t] && s.len() == mp)
                    done = t;
            end
            if (done >= 0)
                take_tag(done);
            else if (mp >= mtst_pkg::MAX_TAG_LEN)
                flush_held();
        endfunction

        // accepted input character: advance the parser and queue its beats
        function void note_char(logic [15:0] c, logic eot);
            logic [15:0] lc;
            logic [15:0] nib;
            logic [31:0] v;
            logic        dflt;
            style_beat_t r;
            em_n = 0;
            lc = lower(c);
            case (phase)
                mtst_pkg::PH_MATCH:
                    match_step(c);
                mtst_pkg::PH_COLOR:
                begin
                    if (c >= mtst_pkg::CH_0 && c <= mtst_pkg::CH_9)
                        acc = {acc[19:0], c[3:0]};
                    else if (lc >= mtst_pkg::CH_LC_A && lc <= mtst_pkg::CH_LC_F)
                    begin
                        nib = lc - mtst_pkg::CH_LC_A + 16'd10;
                        acc = {acc[19:0], nib[3:0]};
                    end
                    else
                        close_param();
                end
                mtst_pkg::PH_SIZE:
                begin
                    if (c >= mtst_pkg::CH_0 && c <= mtst_pkg::CH_9)
                    begin
                        v = {8'h00, acc} * 32'd10 + {28'h0, c[3:0]};
                        acc = (v > 32'd65535) ? 24'd65535 : v[23:0];
                    end
                    else
                        close_param();
                end
                mtst_pkg::PH_URL:
                begin
                    if (c == mtst_pkg::CH_SPACE || c == mtst_pkg::CH_GT)
                        phase = mtst_pkg::PH_IDLE;
                    else
                        emit(c, 1'b1);
                end
                default:
                begin
                    phase = mtst_pkg::PH_IDLE;
                    open_or_text(c);
                end
            endcase

            // end of text flushes whatever is pending
            if (eot)
            begin
                if (phase == mtst_pkg::PH_MATCH)
                    flush_held();
                else if (phase == mtst_pkg::PH_COLOR || phase == mtst_pkg::PH_SIZE)
                    close_param();
                phase = mtst_pkg::PH_IDLE;
            end

            dflt = !bold && !italic && !uline && (style_size == dflt_size);
            for (int k = 0; k < em_n; k++)
            begin
                r.text_char = em_ch[k];
                r.is_text = !em_url[k];
                r.is_url_char = em_url[k];
                r.bold_on = bold;
                r.italic_active = italic;
                r.underline_active = uline;
                r.text_color = color;
                r.text_size = style_size;
                r.default_style = dflt;
                r.last = (k == em_n - 1);
                expected_beats.push_back(r);
            end
        endfunction

        function string describe(style_beat_t b);
            return $sformatf("ch=%h txt=%b url=%b biu=%b%b%b col=%h size=%h dflt=%b last=%b",
                b.text_char, b.is_text, b.is_url_char, b.bold_on, b.italic_active,
                b.underline_active, b.text_color, b.text_size, b.default_style, b.last);
        endfunction

        function void check_beat(style_beat_t got);
            style_beat_t want;
            if (expected_beats.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected beat: %s", describe(got));
                return;
            end
            want = expected_beats.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("beat mismatch, expected %s", describe(want));
                    $display("               actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [mtst_pkg::CFG_ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mtst_in_if  din_if();
    mtst_out_if dout_if();

    markup_tag_style_tracker_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    markup_style_predictor pred;
    char_item_t char_plan[$];
    int  hold_len = 0;
    int  run_left = 0;
    logic run_val = 1'b1;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    int  cycle_count = 0;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side ready: runs of random length, long hold-off on request
    initial
    begin
        int r;
        dout_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                dout_if.ready <= 1'b0;
                hold_len--;
            end
            else
            begin
                if (run_left == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (rx_steady)
                    begin
                        run_val = 1'b1;
                        run_left = 1;
                    end
                    else if (r < 65)
                    begin
                        run_val = 1'b1;
                        run_left = $urandom_range(1, 12);
                    end
                    else if (r < 93)
                    begin
                        run_val = 1'b0;
                        run_left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        run_val = 1'b0;
                        run_left = $urandom_range(15, 50);
                    end
                end
                dout_if.ready <= run_val;
                run_left--;
            end
        end
    end

    // result monitor
    initial
    begin
        style_beat_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && dout_if.valid === 1'b1 && dout_if.ready === 1'b1)
            begin
                got.text_char = dout_if.text_char;
                got.is_text = dout_if.is_text;
                got.is_url_char = dout_if.is_url_char;
                got.bold_on = dout_if.bold_on;
                got.italic_active = dout_if.italic_active;
                got.underline_active = dout_if.underline_active;
                got.text_color = dout_if.text_color;
                got.text_size = dout_if.text_size;
                got.default_style = dout_if.default_style;
                got.last = dout_if.last;
                pred.check_beat(got);
            end
        end
    end

    function int pick_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function void add_char(logic [15:0] c, logic e);
        char_item_t it;
        it.ch = c;
        it.eot = e;
        char_plan.push_back(it);
    endfunction

    function void add_str(string s, logic eot_last);
        for (int k = 0; k < s.len(); k++)
            add_char({8'h00, s[k]}, eot_last && (k == s.len() - 1));
    endfunction

    function logic random_eot();
        return $urandom_range(0, 24) == 0;
    endfunction

    function logic [7:0] mixed_case(logic [7:0] b);
        if (b >= 8'h61 && b <= 8'h7a && $urandom_range(0, 1) == 1)
            return b - 8'h20;
        return b;
    endfunction

    function logic [7:0] hex_digit(int v);
        if (v < 10)
            return 8'h30 + v[7:0];
        return 8'h61 + v[7:0] - 8'd10;
    endfunction

    function logic [15:0] text_char_pick();
        if ($urandom_range(0, 99) < 85)
            return 16'($urandom_range(16'h0020, 16'h007e));
        return 16'($urandom_range(0, 65535));
    endfunction

    // a character that ends a colour or size parameter
    function logic [15:0] param_end();
        case ($urandom_range(0, 4))
            0:       return mtst_pkg::CH_GT;
            1:       return 16'h003b;
            2:       return mtst_pkg::CH_SPACE;
            3:       return 16'h0078;
            default: return 16'($urandom_range(16'h0100, 16'hffff));
        endcase
    endfunction

    // well-formed tags with random content, plain text, broken tags and noise
    function void add_random_token();
        int    r;
        int    t;
        int    n;
        string s;
        logic [15:0] c;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            t = $urandom_range(0, mtst_pkg::NUM_TAGS - 1);
            s = pred.tag_spelling(t);
            for (int k = 0; k < s.len(); k++)
                add_char({8'h00, mixed_case(s[k])}, random_eot());
            if (t == mtst_pkg::TAG_COLOR_ON)
            begin
                n = $urandom_range(0, 8);
                for (int k = 0; k < n; k++)
                    add_char({8'h00, mixed_case(hex_digit($urandom_range(0, 15)))},
                             random_eot());
                if ($urandom_range(0, 9) < 8)
                    add_char(param_end(), random_eot());
            end
            else if (t == mtst_pkg::TAG_SIZE_ON)
            begin
                n = $urandom_range(0, 7);
                for (int k = 0; k < n; k++)
                    add_char(mtst_pkg::CH_0 + 16'($urandom_range(0, 9)), random_eot());
                if ($urandom_range(0, 9) < 8)
                    add_char(param_end(), random_eot());
            end
            else if (t == mtst_pkg::TAG_LINK_ON)
            begin
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++)
                begin
                    c = 16'($urandom_range(16'h0021, 16'h007e));
                    if (c == mtst_pkg::CH_GT)
                        c = 16'h002f;
                    add_char(c, random_eot());
                end
                if ($urandom_range(0, 9) < 9)
                    add_char(($urandom_range(0, 1) == 1) ? mtst_pkg::CH_SPACE : mtst_pkg::CH_GT,
                             random_eot());
            end
        end
        else if (r < 75)
        begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++)
                add_char(text_char_pick(), random_eot());
        end
        else if (r < 90)
        begin
            t = $urandom_range(0, mtst_pkg::NUM_TAGS - 1);
            s = pred.tag_spelling(t);
            n = $urandom_range(1, s.len() - 1);
            for (int k = 0; k < n; k++)
                add_char({8'h00, mixed_case(s[k])}, random_eot());
            add_char(($urandom_range(0, 3) == 0) ? 16'h003c : text_char_pick(), random_eot());
        end
        else
            add_char(16'($urandom_range(0, 65535)), random_eot());
    endfunction

    function void add_random_chars(int count);
        int target;
        target = char_plan.size() + count;
        while (char_plan.size() < target)
            add_random_token();
    endfunction

    // one input beat; valid stays up when the next beat follows without a gap
    task automatic send_char(logic [15:0] c, logic e, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.ch <= c;
        din_if.end_of_text <= e;
        @(posedge clk);
        while (din_if.ready !== 1'b1)
            @(posedge clk);
        pred.note_char(c, e);
    endtask

    // send the planned characters; optional long hold-off on the result side
    task automatic send_plan(int hold);
        for (int i = 0; i < char_plan.size(); i++)
        begin
            send_char(char_plan[i].ch, char_plan[i].eot, pick_gap());
            if (i == 0 && hold > 0)
                hold_len = hold;
        end
        char_plan.delete();
    endtask

    // stop sending and wait until every expected beat has arrived
    task automatic drain_results();
        @(negedge clk);
        din_if.valid <= 1'b0;
        while (pred.expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_default_size(logic [15:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= DFLT_SIZE_ADDR;
        pwdata <= {16'h0000, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pred.dflt_size = v;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        pred = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        din_if.valid = 1'b0;
        din_if.ch = '0;
        din_if.end_of_text = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: char extremes, '<' restart, link, flushed tag, size at end of text
        write_default_size(mtst_pkg::SIZE_RESET);
        add_char(16'hffff, 1'b0);
        add_char(16'h0000, 1'b0);
        add_char(16'h013c, 1'b0);
        add_str("<<B>", 1'b0);
        add_str("x", 1'b0);
        add_str("<a=q ", 1'b0);
        add_str("</", 1'b1);
        add_str("<size=9", 1'b1);
        add_str("z", 1'b0);
        send_plan(0);
        drain_results();

        // random with idling, default size at its minimum
        write_default_size(16'h0000);
        add_random_chars(30);
        send_plan(0);
        drain_results();

        // result side held off while characters keep coming, maximum default size
        write_default_size(16'hffff);
        tx_steady = 1'b1;
        add_random_chars(30);
        send_plan(120);
        drain_results();

        // no idling on either side, random default size
        write_default_size(16'($urandom_range(0, 65535)));
        rx_steady = 1'b1;
        add_random_chars(30);
        send_plan(0);
        drain_results();

        if (pred.errors == 0 && pred.expected_beats.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
